// ===== rtl/mnr_pkg.sv =====
// Shared types and constants for the MIDI note remapper.
// Used by every module under rtl; depends on nothing.
package mnr_pkg;

  localparam int KEY_COUNT     = 128;
  localparam int CHANNEL_COUNT = 16;
  localparam int KEY_W         = $clog2(KEY_COUNT);
  localparam int CH_W          = $clog2(CHANNEL_COUNT);
  localparam int HELD_DEPTH    = CHANNEL_COUNT * KEY_COUNT;
  localparam int HELD_AW       = CH_W + KEY_W;
  localparam int HELD_W        = 8;
  localparam int CFG_W         = 5;
  localparam int CFG_IDX_W     = 2;

  localparam logic [HELD_W-1:0]    HELD_EMPTY         = 8'hFF;
  localparam logic [3:0]           MIDI_KIND_NOTE_ON  = 4'h9;
  localparam logic [3:0]           MIDI_KIND_NOTE_OFF = 4'h8;
  localparam logic [CFG_IDX_W-1:0] REG_INPUT_CHANNEL  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_CHANNEL = 2'd1;

  typedef enum logic [2:0] {
    FUNC_RAW_MIDI  = 3'd0,
    FUNC_NOTE_ON   = 3'd1,
    FUNC_NOTE_OFF  = 3'd2,
    FUNC_NOTE_EXPR = 3'd3,
    FUNC_TABLE_WR  = 3'd4
  } func_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_t;

  typedef struct packed {
    logic             we;
    logic [KEY_W-1:0] waddr;
    logic [KEY_W-1:0] wdata;
    logic             re;
    logic [KEY_W-1:0] raddr;
  } map_req_t;

  typedef struct packed {
    logic               we;
    logic [HELD_AW-1:0] waddr;
    logic [HELD_W-1:0]  wdata;
    logic               re;
    logic [HELD_AW-1:0] raddr;
  } held_req_t;

endpackage

// ===== rtl/midi_note_remapper_core.sv =====
// A result strobes on done after the start transfer: the item and both memory reads
// are registered, the exec state remaps and writes the held note back, then done is
// registered. Busy holds off a new event until that write-back is through; a table write
// gives no done. Reset: the held-note memory is swept to empty while busy stays high.
// Config registers reset to 0; the user must write them between events (not enforced).
module midi_note_remapper_core (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic                               cfg_write,
  input  logic [mnr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mnr_pkg::CFG_W-1:0]          cfg_data,
  input  logic [2:0]                         func,
  input  logic [7:0]                         midi_status,
  input  logic [7:0]                         midi_key,
  input  logic [7:0]                         midi_velocity,
  input  logic signed [4:0]                  note_channel,
  input  logic signed [7:0]                  note_key,
  input  logic [6:0]                         table_index,
  input  logic [6:0]                         table_value,
  output logic                               done,
  output logic [1:0]                         out_kind,
  output logic [7:0]                         out_midi_status,
  output logic [7:0]                         out_midi_key,
  output logic [7:0]                         out_midi_velocity,
  output logic signed [4:0]                  out_note_channel,
  output logic signed [7:0]                  out_note_key
);

  logic [mnr_pkg::CFG_W-1:0]  input_channel;
  logic [mnr_pkg::CFG_W-1:0]  output_channel;
  mnr_pkg::map_req_t          map_req;
  mnr_pkg::held_req_t         held_req;
  logic [mnr_pkg::KEY_W-1:0]  map_rdata;
  logic [mnr_pkg::HELD_W-1:0] held_rdata;
  logic                       held_clearing;

  always_ff @(posedge clk) begin
    if (rst) begin
      input_channel  <= '0;
      output_channel <= '0;
    end else if (cfg_write) begin
      if (cfg_index == mnr_pkg::REG_INPUT_CHANNEL) begin
        input_channel <= cfg_data;
      end
      if (cfg_index == mnr_pkg::REG_OUTPUT_CHANNEL) begin
        output_channel <= cfg_data;
      end
    end
  end

  mnr_key_map u_key_map (
    .clk   (clk),
    .req   (map_req),
    .rdata (map_rdata)
  );

  mnr_held_store u_held_store (
    .clk      (clk),
    .rst      (rst),
    .req      (held_req),
    .rdata    (held_rdata),
    .clearing (held_clearing)
  );

  mnr_seq u_seq (
    .clk               (clk),
    .rst               (rst),
    .start             (start),
    .busy              (busy),
    .func              (func),
    .midi_status       (midi_status),
    .midi_key          (midi_key),
    .midi_velocity     (midi_velocity),
    .note_channel      (note_channel),
    .note_key          (note_key),
    .table_index       (table_index),
    .table_value       (table_value),
    .input_channel     (input_channel),
    .output_channel    (output_channel),
    .map_req           (map_req),
    .map_rdata         (map_rdata),
    .held_req          (held_req),
    .held_rdata        (held_rdata),
    .held_clearing     (held_clearing),
    .done              (done),
    .out_kind          (out_kind),
    .out_midi_status   (out_midi_status),
    .out_midi_key      (out_midi_key),
    .out_midi_velocity (out_midi_velocity),
    .out_note_channel  (out_note_channel),
    .out_note_key      (out_note_key)
  );

endmodule

// ===== rtl/mnr_key_map.sv =====
// Key map memory: one write port, one registered read port.
// Depends on mnr_pkg.
module mnr_key_map (
  input  logic                         clk,
  input  mnr_pkg::map_req_t            req,
  output logic [mnr_pkg::KEY_W-1:0]    rdata
);

  logic [mnr_pkg::KEY_W-1:0] mem [mnr_pkg::KEY_COUNT];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

// ===== rtl/mnr_held_store.sv =====
// Held-note memory with registered read and a clearing sweep after reset.
// Depends on mnr_pkg.
module mnr_held_store (
  input  logic                          clk,
  input  logic                          rst,
  input  mnr_pkg::held_req_t            req,
  output logic [mnr_pkg::HELD_W-1:0]    rdata,
  output logic                          clearing
);

  logic [mnr_pkg::HELD_W-1:0]  mem [mnr_pkg::HELD_DEPTH];
  logic [mnr_pkg::HELD_AW-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == mnr_pkg::HELD_AW'(mnr_pkg::HELD_DEPTH - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= mnr_pkg::HELD_EMPTY;
    end else if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

// ===== rtl/mnr_seq.sv =====
// Event sequencer: accepts an item, reads both memories, then remaps,
// writes the held note back and registers the result. Depends on mnr_pkg.
module mnr_seq (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic [2:0]                       func,
  input  logic [7:0]                       midi_status,
  input  logic [7:0]                       midi_key,
  input  logic [7:0]                       midi_velocity,
  input  logic signed [4:0]                note_channel,
  input  logic signed [7:0]                note_key,
  input  logic [6:0]                       table_index,
  input  logic [6:0]                       table_value,
  input  logic [mnr_pkg::CFG_W-1:0]        input_channel,
  input  logic [mnr_pkg::CFG_W-1:0]        output_channel,
  output mnr_pkg::map_req_t                map_req,
  input  logic [mnr_pkg::KEY_W-1:0]        map_rdata,
  output mnr_pkg::held_req_t               held_req,
  input  logic [mnr_pkg::HELD_W-1:0]       held_rdata,
  input  logic                             held_clearing,
  output logic                             done,
  output logic [1:0]                       out_kind,
  output logic [7:0]                       out_midi_status,
  output logic [7:0]                       out_midi_key,
  output logic [7:0]                       out_midi_velocity,
  output logic signed [4:0]                out_note_channel,
  output logic signed [7:0]                out_note_key
);

  mnr_pkg::state_t state, state_next;

  logic                        accept;
  logic                        is_raw;
  logic [2:0]                  func_q;
  logic [7:0]                  status_q;
  logic [7:0]                  key_q;
  logic [7:0]                  vel_q;
  logic [4:0]                  nch_q;
  logic [7:0]                  nkey_q;
  logic [mnr_pkg::HELD_AW-1:0] idx_q;

  logic [mnr_pkg::CFG_W-1:0]   in_ch_m1;
  logic [3:0]                  new_ch;
  logic [3:0]                  kind;
  logic                        raw_q;
  logic                        sel;
  logic                        proc;
  logic                        held_full;
  logic [7:0]                  mapped;
  logic [7:0]                  res_status;
  logic [7:0]                  res_key;
  logic [4:0]                  res_nch;
  logic [7:0]                  res_nkey;

  assign is_raw = (func == mnr_pkg::FUNC_RAW_MIDI);
  assign accept = start && (state == mnr_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mnr_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    busy       = 1'b1;
    unique case (state)
      mnr_pkg::ST_CLEAR: begin
        if (!held_clearing) begin
          state_next = mnr_pkg::ST_IDLE;
        end
      end
      mnr_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start && func <= mnr_pkg::FUNC_NOTE_EXPR) begin
          state_next = mnr_pkg::ST_EXEC;
        end
      end
      mnr_pkg::ST_EXEC: begin
        state_next = mnr_pkg::ST_IDLE;
      end
      default: begin
        state_next = mnr_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      func_q   <= func;
      status_q <= midi_status;
      key_q    <= midi_key;
      vel_q    <= midi_velocity;
      nch_q    <= note_channel;
      nkey_q   <= note_key;
      idx_q    <= is_raw ? {midi_status[3:0], midi_key[6:0]}
                         : {note_channel[3:0], note_key[6:0]};
    end
  end

  always_comb begin
    map_req       = '0;
    map_req.we    = accept && (func == mnr_pkg::FUNC_TABLE_WR);
    map_req.waddr = table_index;
    map_req.wdata = table_value;
    map_req.re    = accept;
    map_req.raddr = is_raw ? midi_key[6:0] : note_key[6:0];
  end

  always_comb begin
    in_ch_m1   = input_channel - 1'b1;
    new_ch     = 4'(output_channel - 1'b1);
    kind       = status_q[7:4];
    raw_q      = (func_q == mnr_pkg::FUNC_RAW_MIDI);
    mapped     = {1'b0, map_rdata};
    held_full  = (held_rdata != mnr_pkg::HELD_EMPTY);
    res_status = status_q;
    res_key    = key_q;
    res_nch    = nch_q;
    res_nkey   = nkey_q;
    held_req   = '0;
    held_req.re    = accept;
    held_req.raddr = is_raw ? {midi_status[3:0], midi_key[6:0]}
                            : {note_channel[3:0], note_key[6:0]};
    held_req.waddr = idx_q;
    if (raw_q) begin
      sel  = (input_channel == '0) || ({1'b0, status_q[3:0]} == in_ch_m1);
      proc = sel && (kind == mnr_pkg::MIDI_KIND_NOTE_ON ||
                     kind == mnr_pkg::MIDI_KIND_NOTE_OFF);
    end else begin
      sel  = (input_channel == '0) || (!nch_q[4] && ({1'b0, nch_q[3:0]} == in_ch_m1));
      proc = sel && !nkey_q[7];
    end
    if (proc) begin
      if (raw_q) begin
        if (kind == mnr_pkg::MIDI_KIND_NOTE_ON && vel_q != 8'd0) begin
          held_req.wdata = mapped;
          res_key        = mapped;
        end else if (held_full) begin
          held_req.wdata = mnr_pkg::HELD_EMPTY;
          res_key        = held_rdata;
        end
        held_req.we = (kind == mnr_pkg::MIDI_KIND_NOTE_ON && vel_q != 8'd0) || held_full;
        if (output_channel != '0) begin
          res_status = {kind, new_ch};
        end
      end else begin
        if (func_q == mnr_pkg::FUNC_NOTE_ON) begin
          held_req.we    = 1'b1;
          held_req.wdata = mapped;
          res_nkey       = mapped;
        end else if (held_full) begin
          held_req.we    = (func_q == mnr_pkg::FUNC_NOTE_OFF);
          held_req.wdata = mnr_pkg::HELD_EMPTY;
          res_nkey       = held_rdata;
        end
        if (output_channel != '0) begin
          res_nch = {1'b0, new_ch};
        end
      end
    end
    held_req.we = held_req.we && (state == mnr_pkg::ST_EXEC);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (state == mnr_pkg::ST_EXEC);
    end
  end

  always_ff @(posedge clk) begin
    if (state == mnr_pkg::ST_EXEC) begin
      out_kind          <= func_q[1:0];
      out_midi_status   <= raw_q ? res_status : 8'd0;
      out_midi_key      <= raw_q ? res_key    : 8'd0;
      out_midi_velocity <= raw_q ? vel_q      : 8'd0;
      out_note_channel  <= raw_q ? 5'sd0 : res_nch;
      out_note_key      <= raw_q ? 8'sd0 : res_nkey;
    end
  end

endmodule
